### src/cps_pkg.sv
// Shared types and codes of the coalescing pulse scheduler.
`default_nettype none
package cps_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_STOP     = 2'd2;

    // Result status codes carried on the output tuser
    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD       = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;
    localparam logic [2:0] ST_STOPPED   = 3'd5;

    // Output pins and field widths
    localparam int          DRIVE_W      = 12;
    localparam logic [3:0]  OUTPUT_COUNT = 4'd12;
    localparam logic [15:0] DEFAULT_WIDTH_RST = 16'd20;

    // One pending pulse as stored in the table RAM
    typedef struct packed {
        logic [3:0]  out_num;
        logic [31:0] start;
        logic [15:0] width;
    } t_entry;

endpackage
`default_nettype wire

### src/cps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/coalescing_pulse_scheduler_unit.sv
// Top level of the coalescing pulse scheduler: request decode, table walk, result register.
// Each request on the slave stream yields one result on the master stream. A schedule
// request walks the whole table to look for a nearby unfired pulse on the same output and
// for the lowest free slot, then stores the pulse; a tick advances the millisecond counter
// and walks the table raising due outputs and lowering and freeing expired ones. The walk
// visits each slot in S_EVAL and then S_DECIDE, since the table RAM's registered read port
// feeds one shared subtractor; a tick walks every slot, a schedule that is stored or finds
// the table full then passes through S_COMMIT, and a schedule that coalesces stops at the
// matching slot. Stop and rejected requests go straight to the result. The input is ready
// only between requests; a finished result waits in the output register, and a second
// finished result waits in S_DONE, and no request is taken, until the first is taken.
`default_nettype none
module coalescing_pulse_scheduler_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Default width register
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // Request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [3:0] output_number, [35:4] delay_ms, [51:36] width_ms, [55:52] zero
    input  wire logic [55:0] i_s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [11:0] drive_mask, [43:12] time_now_out
    output logic [43:0]      o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]       o_m_axis_tuser
);
    import cps_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [TABLE_DEPTH-1:0] r_used, n_used;
    logic [TABLE_DEPTH-1:0] r_fired, n_fired;
    logic [DRIVE_W-1:0] r_drive, n_drive;
    logic [31:0]        r_time, n_time;
    logic [15:0]        r_dflt_w;
    logic [1:0]         r_req, n_req;
    logic [3:0]         r_num, n_num;
    logic [31:0]        r_start, n_start;
    logic [15:0]        r_width, n_width;
    logic [32:0]        r_diff, n_diff;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [2:0]         r_status, n_status;
    logic               r_m_valid, n_m_valid;
    logic [DRIVE_W-1:0] r_m_drive, n_m_drive;
    logic [2:0]         r_m_status, n_m_status;
    logic [31:0]        r_m_time, n_m_time;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    t_entry             wr_entry;

    logic [3:0]         in_num;
    logic [31:0]        in_delay;
    logic [15:0]        in_width;
    logic               in_fire;
    logic               last;
    logic               cur_used, cur_fired;
    logic [31:0]        sub_a, sub_b;
    logic [32:0]        sub_res;
    logic [31:0]        mag;
    logic               near;
    logic [31:0]        end_time;
    logic               ended;
    logic [15:0]        pin_mask16;
    logic [DRIVE_W-1:0] pin_mask;

    assign in_num   = i_s_axis_tdata[3:0];
    assign in_delay = i_s_axis_tdata[35:4];
    assign in_width = i_s_axis_tdata[51:36];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_time, r_m_drive};
    assign o_m_axis_tuser  = r_m_status;

    // Read the next slot while deciding on the current one
    assign ram_raddr = (r_state == S_DECIDE) ? r_idx + IDX_W'(1) : r_idx;
    assign rd_entry  = t_entry'(ram_rdata);
    assign wr_entry  = '{out_num: r_num, start: r_start, width: r_width};
    assign ram_we    = (r_state == S_COMMIT) && r_free_found;

    cps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared subtractor: slot start minus request start, or now minus slot start
    always_comb begin
        if (r_req == REQ_TICK) begin
            sub_a = r_time;
            sub_b = rd_entry.start;
        end else begin
            sub_a = rd_entry.start;
            sub_b = r_start;
        end
        sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    end

    // Per-slot tests on the registered difference and the stored entry
    assign mag        = r_diff[32] ? (~r_diff[31:0] + 32'd1) : r_diff[31:0];
    assign near       = mag < {16'd0, r_width};
    assign end_time   = rd_entry.start + {16'd0, rd_entry.width};
    assign ended      = r_time >= end_time;
    assign pin_mask16 = 16'd1 << (rd_entry.out_num - 4'd1);
    assign pin_mask   = pin_mask16[DRIVE_W-1:0];
    assign last       = (r_idx == LAST_IDX);
    assign cur_used   = r_used[r_idx];
    assign cur_fired  = r_fired[r_idx];

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_fired      = r_fired;
        n_drive      = r_drive;
        n_time       = r_time;
        n_req        = r_req;
        n_num        = r_num;
        n_start      = r_start;
        n_width      = r_width;
        n_diff       = r_diff;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_status     = r_status;
        n_m_valid    = r_m_valid && !i_m_axis_tready;
        n_m_drive    = r_m_drive;
        n_m_status   = r_m_status;
        n_m_time     = r_m_time;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_req = i_s_axis_tuser;
                    n_idx = '0;
                    unique case (i_s_axis_tuser)
                        REQ_SCHEDULE: begin
                            if (in_num == 4'd0 || in_num > OUTPUT_COUNT) begin
                                n_status = ST_BAD;
                                n_state  = S_DONE;
                            end else begin
                                n_num        = in_num;
                                n_start      = r_time + in_delay;
                                n_width      = (in_width == 16'd0) ? r_dflt_w : in_width;
                                n_free_found = 1'b0;
                                n_state      = S_EVAL;
                            end
                        end
                        REQ_TICK: begin
                            n_time  = r_time + 32'd1;
                            n_state = S_EVAL;
                        end
                        REQ_STOP: begin
                            n_used   = '0;
                            n_fired  = '0;
                            n_drive  = '0;
                            n_status = ST_STOPPED;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_diff  = sub_res;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_req == REQ_TICK) begin
                    // Raise a due pulse, or lower and free an expired one
                    if (cur_used && !cur_fired && !r_diff[32]) begin
                        n_drive        = r_drive | pin_mask;
                        n_fired[r_idx] = 1'b1;
                    end else if (cur_used && cur_fired && ended) begin
                        n_drive        = r_drive & ~pin_mask;
                        n_used[r_idx]  = 1'b0;
                        n_fired[r_idx] = 1'b0;
                    end
                    if (last) begin
                        n_idx    = '0;
                        n_status = ST_TICK;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_EVAL;
                    end
                end else if (cur_used && !cur_fired && rd_entry.out_num == r_num && near) begin
                    // Drop the request into the nearby pending pulse
                    n_idx    = '0;
                    n_status = ST_COALESCED;
                    n_state  = S_DONE;
                end else begin
                    if (!cur_used && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (last) begin
                        n_idx   = '0;
                        n_state = S_COMMIT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_EVAL;
                    end
                end
            end
            S_COMMIT: begin
                // Store the pulse in the lowest free slot
                if (r_free_found) begin
                    n_used[r_free_idx]  = 1'b1;
                    n_fired[r_free_idx] = 1'b0;
                    n_status            = ST_SCHEDULED;
                end else begin
                    n_status = ST_FULL;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_drive  = r_drive;
                    n_m_status = r_status;
                    n_m_time   = r_time;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, table flags and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_used    <= '0;
            r_fired   <= '0;
            r_drive   <= '0;
            r_time    <= '0;
            r_dflt_w  <= DEFAULT_WIDTH_RST;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_fired   <= n_fired;
            r_drive   <= n_drive;
            r_time    <= n_time;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_dflt_w <= i_cfg_wdata;
            end
        end
        r_req        <= n_req;
        r_num        <= n_num;
        r_start      <= n_start;
        r_width      <= n_width;
        r_diff       <= n_diff;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_m_drive    <= n_m_drive;
        r_m_status   <= n_m_status;
        r_m_time     <= n_m_time;
    end

endmodule
`default_nettype wire
